@@ design/lsoa_pkg.sv @@
// Shared types, register indexes and constants of the lidar sector obstacle avoider.
package lsoa_pkg;

  typedef enum logic [2:0] {
    MODE_FORWARD   = 3'd0,
    MODE_LEFT      = 3'd1,
    MODE_RIGHT     = 3'd2,
    MODE_EXPLORING = 3'd3,
    MODE_REVERSING = 3'd4
  } mode_t;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_LIMIT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_LIMIT    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MINIMUM  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAXIMUM  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LENGTH    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_SPEED   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_RATE       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_ENABLE   = 4'd7;

  localparam int DEF_MAX_SAMPLES         = 4096;
  localparam int DEF_MIN_TURN_TICKS      = 30;
  localparam int DEF_REVERSE_TICKS       = 40;
  localparam int DEF_EXPLORE_AFTER_TICKS = 160;

  localparam logic [16:0] NO_RANGE        = 17'd100000;
  localparam logic [9:0]  RETURN_CHANCE   = 10'd51;
  localparam logic [9:0]  EXPLORE_CHANCE  = 10'd307;
  localparam logic signed [12:0] EXPLORE_TURN = 13'sd150;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

endpackage

@@ design/lidar_sector_obstacle_avoider.sv @@
// Top level of the lidar sector obstacle avoider: scan minima, mode control and reports.
//
// Usage. Requests enter on the input channel (in_valid / in_stall) and carry either one
// lidar range sample (op = 0) or one 50 ms control tick (op = 1). A request is taken at a
// rising edge where in_valid is high and in_stall is low. Samples of a scan are folded into
// the right, front and left running minima; only the last sample of a scan produces a
// result, the scan report, after which the minima start afresh. Every tick produces a
// velocity command for the mode in force, and may end reversing after its timeout.
// Results leave on the output channel (out_valid / out_stall) from a single result register.
// One request is taken every cycle while in_stall is low, and its result is registered. The
// whole of a request's work sits between the state registers and the result register.
// When the receiver stalls, the pending result holds still and in_stall rises only for a
// request that would produce a further result; ordinary samples keep flowing.
// Registers are written through cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data, and should only be written while the block is idle.
// Synchronous reset (rst) restores the register defaults, forward mode, cleared counters
// and empty minima, and empties the result register.
module lidar_sector_obstacle_avoider #(
  parameter int MAX_SAMPLES         = lsoa_pkg::DEF_MAX_SAMPLES,
  parameter int MIN_TURN_TICKS      = lsoa_pkg::DEF_MIN_TURN_TICKS,
  parameter int REVERSE_TICKS       = lsoa_pkg::DEF_REVERSE_TICKS,
  parameter int EXPLORE_AFTER_TICKS = lsoa_pkg::DEF_EXPLORE_AFTER_TICKS
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsoa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [15:0]                       range_mm,
  input  logic                              sample_valid,
  input  logic                              last_sample,
  input  logic [9:0]                        chance_return,
  input  logic [9:0]                        chance_explore,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              report_kind,
  output logic [2:0]                        mode_code,
  output logic                              obstacle_flag,
  output logic [16:0]                       front_clearance,
  output logic [16:0]                       left_clearance,
  output logic [16:0]                       right_clearance,
  output logic signed [12:0]                linear_velocity,
  output logic signed [12:0]                angular_velocity,
  output logic [15:0]                       explore_count
);
  import lsoa_pkg::*;

  localparam int PW = $clog2(MAX_SAMPLES);

  // Configuration registers.
  logic [15:0] obstacle_limit;
  logic [15:0] clear_limit;
  logic [15:0] range_minimum;
  logic [15:0] range_maximum;
  logic [12:0] scan_length;
  logic [11:0] cruise_speed;
  logic [11:0] yaw_rate;
  logic        drive_enable;

  // Navigation state.
  mode_t         mode, mode_next;
  logic [PW-1:0] sample_position, sample_position_next;
  logic [16:0]   front_min, front_min_next;
  logic [16:0]   left_min, left_min_next;
  logic [16:0]   right_min, right_min_next;
  logic          obstacle_seen, obstacle_seen_next;
  logic [7:0]    turn_ticks, turn_ticks_next;
  logic [7:0]    forward_ticks, forward_ticks_next;
  logic [15:0]   explore_total, explore_total_next;

  // Result fields before the result register.
  logic               res_kind;
  mode_t              res_mode;
  logic               res_obstacle;
  logic [16:0]        res_front, res_left, res_right;
  logic signed [12:0] res_lin, res_ang;
  logic [15:0]        res_explore;

  logic in_take;
  logic makes_result;

  // Sector bounds from the effective scan length.
  logic [12:0] scan_n;
  logic [15:0] n3, n5, n7;
  logic [16:0] b1, b3, b5, b7, pos_ext;
  logic        range_ok, in_front, in_left, in_right;
  logic [16:0] front_fold, left_fold, right_fold;
  logic        obstacle_fold;

  logic [7:0]         turn_inc, forward_inc;
  logic signed [12:0] cmd_lin, cmd_ang;

  // Scan decision intermediates.
  mode_t       mode_mid;
  logic [7:0]  forward_mid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_limit <= 16'd2000;
      clear_limit    <= 16'd3000;
      range_minimum  <= 16'd0;
      range_maximum  <= 16'd65535;
      scan_length    <= 13'd360;
      cruise_speed   <= 12'd400;
      yaw_rate       <= 12'd500;
      drive_enable   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OBSTACLE_LIMIT: obstacle_limit <= cfg_data;
        REG_CLEAR_LIMIT:    clear_limit    <= cfg_data;
        REG_RANGE_MINIMUM:  range_minimum  <= cfg_data;
        REG_RANGE_MAXIMUM:  range_maximum  <= cfg_data;
        REG_SCAN_LENGTH:    scan_length    <= cfg_data[12:0];
        REG_CRUISE_SPEED:   cruise_speed   <= cfg_data[11:0];
        REG_YAW_RATE:       yaw_rate       <= cfg_data[11:0];
        REG_DRIVE_ENABLE:   drive_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Only requests that yield a result must wait for the result register to drain.
  assign makes_result = (op == OP_TICK) || last_sample;
  assign in_stall     = out_valid && out_stall && makes_result;
  assign in_take      = in_valid && !in_stall;

  // A scan longer than the position counter can index is clipped to it.
  assign scan_n = (17'(scan_length) > 17'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES) : scan_length;
  assign n3 = (16'(scan_n) << 1) + 16'(scan_n);
  assign n5 = (16'(scan_n) << 2) + 16'(scan_n);
  assign n7 = (16'(scan_n) << 3) - 16'(scan_n);
  assign b1 = 17'(scan_n[12:3]);
  assign b3 = 17'(n3[15:3]);
  assign b5 = 17'(n5[15:3]);
  assign b7 = 17'(n7[15:3]);
  assign pos_ext = 17'(sample_position);

  assign range_ok = sample_valid && (range_mm >= range_minimum) && (range_mm <= range_maximum);
  assign in_front = range_ok && (pos_ext >= b3) && (pos_ext < b5);
  assign in_left  = range_ok && !in_front && (pos_ext >= b5) && (pos_ext < b7);
  assign in_right = range_ok && !in_front && !in_left && (pos_ext >= b1) && (pos_ext < b3);

  assign front_fold = (in_front && (17'(range_mm) < front_min)) ? 17'(range_mm) : front_min;
  assign left_fold  = (in_left && (17'(range_mm) < left_min)) ? 17'(range_mm) : left_min;
  assign right_fold = (in_right && (17'(range_mm) < right_min)) ? 17'(range_mm) : right_min;
  assign obstacle_fold = obstacle_seen || (in_front && (range_mm < obstacle_limit));

  assign turn_inc    = (turn_ticks == 8'hFF) ? turn_ticks : turn_ticks + 8'd1;
  assign forward_inc = (forward_ticks == 8'hFF) ? forward_ticks : forward_ticks + 8'd1;

  lsoa_velocity u_velocity (
    .mode             (mode),
    .cruise_speed     (cruise_speed),
    .yaw_rate         (yaw_rate),
    .drive_enable     (drive_enable),
    .linear_velocity  (cmd_lin),
    .angular_velocity (cmd_ang)
  );

  always_comb begin
    mode_next            = mode;
    sample_position_next = sample_position;
    front_min_next       = front_min;
    left_min_next        = left_min;
    right_min_next       = right_min;
    obstacle_seen_next   = obstacle_seen;
    turn_ticks_next      = turn_ticks;
    forward_ticks_next   = forward_ticks;
    explore_total_next   = explore_total;
    mode_mid             = mode;
    forward_mid          = forward_ticks;

    res_kind     = KIND_TICK;
    res_mode     = mode;
    res_obstacle = 1'b0;
    res_front    = '0;
    res_left     = '0;
    res_right    = '0;
    res_lin      = cmd_lin;
    res_ang      = cmd_ang;
    res_explore  = explore_total;

    if (in_take) begin
      if (op == OP_TICK) begin
        turn_ticks_next    = turn_inc;
        forward_ticks_next = forward_inc;
        // Reversing gives way to a left turn once it has run long enough.
        if (drive_enable && (mode == MODE_REVERSING) &&
            (turn_inc > 8'(REVERSE_TICKS))) begin
          mode_next       = MODE_LEFT;
          turn_ticks_next = '0;
        end
      end else begin
        front_min_next     = front_fold;
        left_min_next      = left_fold;
        right_min_next     = right_fold;
        obstacle_seen_next = obstacle_fold;
        if (sample_position < PW'(MAX_SAMPLES - 1)) begin
          sample_position_next = sample_position + PW'(1);
        end
        if (last_sample) begin
          if (obstacle_fold && (mode == MODE_FORWARD)) begin
            if ((left_fold > right_fold) && (left_fold > 17'(obstacle_limit))) begin
              mode_mid = MODE_LEFT;
            end else if ((right_fold > left_fold) &&
                         (right_fold > 17'(obstacle_limit))) begin
              mode_mid = MODE_RIGHT;
            end else begin
              mode_mid = MODE_REVERSING;
            end
            turn_ticks_next = '0;
          end else if (!obstacle_fold && (front_fold > 17'(clear_limit))) begin
            if ((mode == MODE_LEFT) || (mode == MODE_RIGHT) || (mode == MODE_REVERSING)) begin
              if (turn_ticks > 8'(MIN_TURN_TICKS)) begin
                mode_mid    = MODE_FORWARD;
                forward_mid = '0;
                if (explore_total != 16'hFFFF) begin
                  explore_total_next = explore_total + 16'd1;
                end
              end
            end else if (mode == MODE_EXPLORING) begin
              if (chance_return < RETURN_CHANCE) begin
                mode_mid = MODE_FORWARD;
              end
            end
          end
          mode_next          = mode_mid;
          forward_ticks_next = forward_mid;
          // Now and then a long straight run turns into a spell of exploring.
          if ((mode_mid == MODE_FORWARD) && (forward_mid > 8'(EXPLORE_AFTER_TICKS))) begin
            if (chance_explore < EXPLORE_CHANCE) begin
              mode_next = MODE_EXPLORING;
            end
            forward_ticks_next = '0;
          end

          res_kind     = KIND_SCAN;
          res_mode     = mode_next;
          res_obstacle = obstacle_fold;
          res_front    = front_fold;
          res_left     = left_fold;
          res_right    = right_fold;
          res_lin      = '0;
          res_ang      = '0;
          res_explore  = explore_total_next;

          sample_position_next = '0;
          front_min_next       = NO_RANGE;
          left_min_next        = NO_RANGE;
          right_min_next       = NO_RANGE;
          obstacle_seen_next   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_FORWARD;
      sample_position <= '0;
      front_min       <= NO_RANGE;
      left_min        <= NO_RANGE;
      right_min       <= NO_RANGE;
      obstacle_seen   <= 1'b0;
      turn_ticks      <= '0;
      forward_ticks   <= '0;
      explore_total   <= '0;
    end else begin
      mode            <= mode_next;
      sample_position <= sample_position_next;
      front_min       <= front_min_next;
      left_min        <= left_min_next;
      right_min       <= right_min_next;
      obstacle_seen   <= obstacle_seen_next;
      turn_ticks      <= turn_ticks_next;
      forward_ticks   <= forward_ticks_next;
      explore_total   <= explore_total_next;
    end
  end

  // Result register: loads whenever a request yields a result, drains when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && makes_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && makes_result) begin
      report_kind      <= res_kind;
      mode_code        <= res_mode;
      obstacle_flag    <= res_obstacle;
      front_clearance  <= res_front;
      left_clearance   <= res_left;
      right_clearance  <= res_right;
      linear_velocity  <= res_lin;
      angular_velocity <= res_ang;
      explore_count    <= res_explore;
    end
  end

endmodule

@@ design/lsoa_velocity.sv @@
// Velocity command for the current navigation mode.
module lsoa_velocity (
  input  lsoa_pkg::mode_t     mode,
  input  logic [11:0]         cruise_speed,
  input  logic [11:0]         yaw_rate,
  input  logic                drive_enable,
  output logic signed [12:0]  linear_velocity,
  output logic signed [12:0]  angular_velocity
);
  import lsoa_pkg::*;

  logic [14:0] scaled;
  logic [31:0] product;
  logic [12:0] seventy_pct;
  logic [12:0] half_fs;
  logic [12:0] half_ts;

  // round(0.7 * fs) = (7 fs + 5) / 10, the division done by reciprocal multiply.
  assign scaled      = 15'({cruise_speed, 3'b000}) - 15'(cruise_speed) + 15'd5;
  assign product     = 32'(scaled) * 32'd52429;
  assign seventy_pct = 13'(product[31:19]);
  assign half_fs     = (13'(cruise_speed) + 13'd1) >> 1;
  assign half_ts     = (13'(yaw_rate) + 13'd1) >> 1;

  always_comb begin
    linear_velocity  = '0;
    angular_velocity = '0;
    if (drive_enable) begin
      case (mode)
        MODE_FORWARD: begin
          linear_velocity = $signed(13'(cruise_speed));
        end
        MODE_LEFT: begin
          angular_velocity = $signed(13'(yaw_rate));
        end
        MODE_RIGHT: begin
          angular_velocity = -$signed(13'(yaw_rate));
        end
        MODE_EXPLORING: begin
          linear_velocity  = $signed(seventy_pct);
          angular_velocity = EXPLORE_TURN;
        end
        MODE_REVERSING: begin
          linear_velocity  = -$signed(half_fs);
          angular_velocity = $signed(half_ts);
        end
        default: begin
          linear_velocity  = '0;
          angular_velocity = '0;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of the lidar sector obstacle avoider, with its own navigation model.
`timescale 1ns / 1ps

module tb;
  import lsoa_pkg::*;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 400000;
  // Settling time after the last expected report, covering requests without results.
  localparam int SETTLE_CYCLES = 4;
  // Register indexes beyond the defined list, which the block must ignore.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 4'd8;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 4'd15;
  // Sectors of a scan, used only to shape the stimulus.
  localparam int SECTOR_FRONT = 0;
  localparam int SECTOR_LEFT  = 1;
  localparam int SECTOR_RIGHT = 2;
  localparam int SECTOR_NONE  = 3;

  typedef struct {
    logic        op;
    logic [15:0] mm;
    logic        valid;
    logic        last;
    logic [9:0]  chance_ret;
    logic [9:0]  chance_exp;
  } request_t;

  typedef struct {
    logic               kind;
    logic [2:0]         mode;
    logic               obstacle;
    logic [16:0]        front;
    logic [16:0]        left;
    logic [16:0]        right;
    logic signed [12:0] lin;
    logic signed [12:0] ang;
    logic [15:0]        explores;
  } report_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   op;
  logic [15:0]            range_mm;
  logic                   sample_valid;
  logic                   last_sample;
  logic [9:0]             chance_return;
  logic [9:0]             chance_explore;
  logic                   out_valid;
  logic                   out_stall;
  logic                   report_kind;
  logic [2:0]             mode_code;
  logic                   obstacle_flag;
  logic [16:0]            front_clearance;
  logic [16:0]            left_clearance;
  logic [16:0]            right_clearance;
  logic signed [12:0]     linear_velocity;
  logic signed [12:0]     angular_velocity;
  logic [15:0]            explore_count;

  lidar_sector_obstacle_avoider dut (.*);

  // Register copies held by the navigation model.
  logic [15:0] cfg_obstacle, cfg_safe, cfg_range_lo, cfg_range_hi;
  logic [12:0] cfg_scan_len;
  logic [11:0] cfg_fwd_speed, cfg_turn_speed;
  logic        cfg_patrol;

  // Navigation state held by the model.
  mode_t       nav_mode;
  int          scan_pos;
  logic [16:0] min_front, min_left, min_right;
  logic        obstacle_seen;
  logic [7:0]  turn_ticks, fwd_ticks;
  logic [15:0] explores;

  report_t expected_reports[$];
  int      mismatches = 0;
  int      requests_sent = 0;
  int      cycles_run = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      hold_cycles = 0;

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Navigation model. It is stepped once for every request taken by the block, in the same
  // order, and queues the report that the request must produce, if any.
  // ---------------------------------------------------------------------------------------

  task automatic clear_scan_minima();
    scan_pos      = 0;
    min_front     = NO_RANGE;
    min_left      = NO_RANGE;
    min_right     = NO_RANGE;
    obstacle_seen = 1'b0;
  endtask

  task automatic reset_navigation();
    cfg_obstacle   = 16'd2000;
    cfg_safe       = 16'd3000;
    cfg_range_lo   = 16'd0;
    cfg_range_hi   = 16'd65535;
    cfg_scan_len   = 13'd360;
    cfg_fwd_speed  = 12'd400;
    cfg_turn_speed = 12'd500;
    cfg_patrol     = 1'b1;
    nav_mode       = MODE_FORWARD;
    turn_ticks     = '0;
    fwd_ticks      = '0;
    explores       = '0;
    clear_scan_minima();
  endtask

  task automatic predict_navigation(input request_t r);
    report_t rep;
    mode_t   shown;
    int      n, b1, b3, b5, b7, p, fs, ts, lin, ang;
    rep.kind = KIND_SCAN;
    rep.mode = nav_mode;
    rep.obstacle = 1'b0;
    rep.front = '0;
    rep.left = '0;
    rep.right = '0;
    rep.lin = '0;
    rep.ang = '0;
    if (r.op == OP_SAMPLE) begin
      // Sector bounds are floor(k*N/8), with N clamped to the number of position slots.
      n  = (cfg_scan_len > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : int'(cfg_scan_len);
      b1 = n >> 3;
      b3 = (3 * n) >> 3;
      b5 = (5 * n) >> 3;
      b7 = (7 * n) >> 3;
      p  = scan_pos;
      if (r.valid && r.mm >= cfg_range_lo && r.mm <= cfg_range_hi) begin
        if (p >= b3 && p < b5) begin
          if (r.mm < min_front) min_front = r.mm;
          if (r.mm < cfg_obstacle) obstacle_seen = 1'b1;
        end else if (p >= b5 && p < b7) begin
          if (r.mm < min_left) min_left = r.mm;
        end else if (p >= b1 && p < b3) begin
          if (r.mm < min_right) min_right = r.mm;
        end
      end
      if (p < DEF_MAX_SAMPLES - 1) scan_pos = p + 1;
      if (r.last) begin
        if (obstacle_seen && nav_mode == MODE_FORWARD) begin
          // Turn towards the more open side, or back off when neither side is open.
          if (min_left > min_right && min_left > cfg_obstacle) nav_mode = MODE_LEFT;
          else if (min_right > min_left && min_right > cfg_obstacle) nav_mode = MODE_RIGHT;
          else nav_mode = MODE_REVERSING;
          turn_ticks = '0;
        end else if (!obstacle_seen && min_front > cfg_safe) begin
          if (nav_mode == MODE_LEFT || nav_mode == MODE_RIGHT ||
              nav_mode == MODE_REVERSING) begin
            if (turn_ticks > DEF_MIN_TURN_TICKS) begin
              nav_mode  = MODE_FORWARD;
              fwd_ticks = '0;
              if (explores != 16'hFFFF) explores++;
            end
          end else if (nav_mode == MODE_EXPLORING) begin
            if (r.chance_ret < RETURN_CHANCE) nav_mode = MODE_FORWARD;
          end
        end
        if (nav_mode == MODE_FORWARD && fwd_ticks > DEF_EXPLORE_AFTER_TICKS) begin
          if (r.chance_exp < EXPLORE_CHANCE) nav_mode = MODE_EXPLORING;
          fwd_ticks = '0;
        end
        rep.mode     = nav_mode;
        rep.obstacle = obstacle_seen;
        rep.front    = min_front;
        rep.left     = min_left;
        rep.right    = min_right;
        rep.explores = explores;
        expected_reports.push_back(rep);
        clear_scan_minima();
      end
    end else begin
      shown = nav_mode;
      if (turn_ticks != 8'hFF) turn_ticks++;
      if (fwd_ticks != 8'hFF) fwd_ticks++;
      lin = 0;
      ang = 0;
      fs  = cfg_fwd_speed;
      ts  = cfg_turn_speed;
      if (cfg_patrol) begin
        case (nav_mode)
          MODE_FORWARD: lin = fs;
          MODE_LEFT: ang = ts;
          MODE_RIGHT: ang = -ts;
          MODE_EXPLORING: begin
            lin = (fs * 7 + 5) / 10;
            ang = EXPLORE_TURN;
          end
          MODE_REVERSING: begin
            lin = -((fs + 1) / 2);
            ang = (ts + 1) / 2;
            // The reversing timeout only runs while patrolling.
            if (turn_ticks > DEF_REVERSE_TICKS) begin
              nav_mode   = MODE_LEFT;
              turn_ticks = '0;
            end
          end
          default: ;
        endcase
      end
      rep.kind     = KIND_TICK;
      rep.mode     = shown;
      rep.lin      = 13'(lin);
      rep.ang      = 13'(ang);
      rep.explores = explores;
      expected_reports.push_back(rep);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking. Each report taken from the block is compared with the oldest one
  // still expected.
  // ---------------------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t ns: report expected none, got kind %0d mode %0d", $time,
                 report_kind, mode_code);
      end else begin
        want = expected_reports.pop_front();
        check_field("report_kind", want.kind, report_kind);
        check_field("mode_code", want.mode, mode_code);
        check_field("obstacle_flag", want.obstacle, obstacle_flag);
        check_field("front_clearance", want.front, front_clearance);
        check_field("left_clearance", want.left, left_clearance);
        check_field("right_clearance", want.right, right_clearance);
        check_field("linear_velocity", want.lin, linear_velocity);
        check_field("angular_velocity", want.ang, angular_velocity);
        check_field("explore_count", want.explores, explore_count);
      end
    end
  end

  // The receiver stalls at random, or holds off for a counted stretch when one is asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: a run that hangs or never drains fails here.
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Request and register drivers.
  // ---------------------------------------------------------------------------------------

  // Offers one request and holds it still until the block takes it. The valid is only
  // lowered when an idle gap really follows, so back-to-back requests keep it high.
  task automatic send_request(input request_t r);
    op             <= r.op;
    range_mm       <= r.mm;
    sample_valid   <= r.valid;
    last_sample    <= r.last;
    chance_return  <= r.chance_ret;
    chance_explore <= r.chance_exp;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_navigation(r);
    requests_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_OBSTACLE_LIMIT: cfg_obstacle = value;
      REG_CLEAR_LIMIT:    cfg_safe = value;
      REG_RANGE_MINIMUM:  cfg_range_lo = value;
      REG_RANGE_MAXIMUM:  cfg_range_hi = value;
      REG_SCAN_LENGTH:    cfg_scan_len = value[12:0];
      REG_CRUISE_SPEED:   cfg_fwd_speed = value[11:0];
      REG_YAW_RATE:       cfg_turn_speed = value[11:0];
      REG_DRIVE_ENABLE:   cfg_patrol = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int od, input int sd, input int lo, input int hi,
                           input int n, input int fs, input int ts, input int en);
    write_register(REG_OBSTACLE_LIMIT, 16'(od));
    write_register(REG_CLEAR_LIMIT, 16'(sd));
    write_register(REG_RANGE_MINIMUM, 16'(lo));
    write_register(REG_RANGE_MAXIMUM, 16'(hi));
    write_register(REG_SCAN_LENGTH, 16'(n));
    write_register(REG_CRUISE_SPEED, 16'(fs));
    write_register(REG_YAW_RATE, 16'(ts));
    write_register(REG_DRIVE_ENABLE, 16'(en));
  endtask

  // Stops offering requests and waits until every expected report has arrived, then lets
  // the block settle so that registers may be written safely.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] mm, input logic valid, input logic last,
                             input logic [9:0] cret, input logic [9:0] cexp);
    request_t r;
    r.op = OP_SAMPLE;
    r.mm = mm;
    r.valid = valid;
    r.last = last;
    r.chance_ret = cret;
    r.chance_exp = cexp;
    send_request(r);
  endtask

  // Control ticks; the sample fields carry noise that the block must ignore.
  task automatic send_ticks(input int count);
    request_t r;
    repeat (count) begin
      r.op = OP_TICK;
      r.mm = 16'($urandom_range(65535));
      r.valid = 1'($urandom_range(1));
      r.last = 1'($urandom_range(1));
      r.chance_ret = 10'($urandom_range(1023));
      r.chance_exp = 10'($urandom_range(1023));
      send_request(r);
    end
  endtask

  // One scan of the given number of samples, the last one flagged. Each sector gets a base
  // range chosen to provoke an obstacle, a clear path, ties between left and right, or an
  // empty sector, and the samples scatter around it with some invalid and wild values.
  task automatic send_scan(input int count);
    request_t r;
    int       base[4];
    logic     silent[4];
    int       n, b1, b3, b5, b7, p, sector, jitter, v;
    n  = (cfg_scan_len > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : int'(cfg_scan_len);
    b1 = n >> 3;
    b3 = (3 * n) >> 3;
    b5 = (5 * n) >> 3;
    b7 = (7 * n) >> 3;
    case ($urandom_range(3))
      0: base[SECTOR_FRONT] = (cfg_obstacle == 0) ? 0 : $urandom_range(cfg_obstacle - 1);
      1, 2: base[SECTOR_FRONT] = cfg_safe + 1 + $urandom_range(3000);
      default: base[SECTOR_FRONT] = $urandom_range(65535);
    endcase
    base[SECTOR_LEFT]  = $urandom_range(65535);
    base[SECTOR_RIGHT] = ($urandom_range(2) == 0) ? base[SECTOR_LEFT] : $urandom_range(65535);
    base[SECTOR_NONE]  = $urandom_range(65535);
    for (int s = 0; s < 4; s++) silent[s] = ($urandom_range(7) == 0);
    jitter = $urandom_range(1) ? 0 : $urandom_range(200);
    for (int i = 0; i < count; i++) begin
      p = scan_pos;
      if (p >= b3 && p < b5) sector = SECTOR_FRONT;
      else if (p >= b5 && p < b7) sector = SECTOR_LEFT;
      else if (p >= b1 && p < b3) sector = SECTOR_RIGHT;
      else sector = SECTOR_NONE;
      v = base[sector] + ((jitter == 0) ? 0 : $urandom_range(jitter));
      if ($urandom_range(19) == 0) v = $urandom_range(65535);
      r.op = OP_SAMPLE;
      r.mm = (v > 65535) ? 16'hFFFF : v[15:0];
      r.valid = !silent[sector] && ($urandom_range(19) != 0);
      r.last = (i == count - 1);
      // Draws cluster around the decision thresholds half of the time.
      r.chance_ret = $urandom_range(1) ? 10'($urandom_range(60)) : 10'($urandom_range(1023));
      r.chance_exp = $urandom_range(1) ? 10'($urandom_range(250, 360))
                                       : 10'($urandom_range(1023));
      send_request(r);
    end
  endtask

  // Random patrol: runs of control ticks, short, medium or long enough to pass the turn,
  // reversing and exploration thresholds, each followed by a scan that is usually
  // well formed and sometimes too short or too long.
  task automatic run_patrol(input int target);
    int start, pick, n, count;
    start = requests_sent;
    while (requests_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 8) send_ticks($urandom_range(150, 300));
      else if (pick < 45) send_ticks($urandom_range(28, 45));
      else send_ticks($urandom_range(0, 6));
      n = (cfg_scan_len > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : int'(cfg_scan_len);
      if ($urandom_range(9) < 8) count = (n == 0) ? 1 : n;
      else count = $urandom_range(1, n + 8);
      send_scan(count);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Hand-made cases: a tick at the register defaults, then an eight-sample scan: right = positions
  // 1-2, front 3-4, left 5-6, positions 0 and 7 in no sector. Then patrol off, an empty scan length,
  // an oversized scan length, writes to unused indexes and excess samples.
  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_ticks(1);
    wait_drained();
    write_register(REG_SCAN_LENGTH, 16'd8);
    send_sample(16'd65535, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd1000, 1'b1, 1'b0, 10'd50, 10'd306);
    send_sample(16'd0, 1'b0, 1'b0, 10'd51, 10'd307);
    send_sample(16'd0, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd65535, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd65535, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd40000, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd0, 1'b1, 1'b1, 10'd1023, 10'd1023);
    send_ticks(1);
    wait_drained();
    write_register(REG_DRIVE_ENABLE, 16'd0);
    send_ticks(1);
    wait_drained();
    write_register(REG_DRIVE_ENABLE, 16'd1);
    write_register(REG_SCAN_LENGTH, 16'd0);
    send_sample(16'd0, 1'b1, 1'b1, 10'd0, 10'd0);
    wait_drained();
    write_register(REG_SCAN_LENGTH, 16'd8191);
    send_sample(16'd5, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd6, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd7, 1'b1, 1'b1, 10'd0, 10'd0);
    wait_drained();
    // An aliased decode of these indexes would change the obstacle distance or patrol.
    write_register(REG_SPARE_FIRST, 16'hFFFF);
    write_register(REG_SPARE_LAST, 16'h0000);
    write_register(REG_SCAN_LENGTH, 16'd2);
    send_sample(16'd1500, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd100, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd200, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd300, 1'b1, 1'b0, 10'd0, 10'd0);
    send_sample(16'd400, 1'b1, 1'b1, 10'd0, 10'd0);
  endtask

  task automatic test_steady_patrol();
    wait_drained();
    configure(2000, 3000, 0, 65535, 16, 400, 500, 1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_patrol(250);
  endtask

  task automatic test_sender_gaps();
    int od;
    wait_drained();
    od = $urandom_range(500, 3000);
    configure(od, od + $urandom_range(2000), 100, 60000, $urandom_range(8, 40), 4000, 4000, 1);
    sender_idle_pct = 52;
    receiver_stall_pct = 0;
    run_patrol(250);
  endtask

  task automatic test_receiver_stalls();
    wait_drained();
    configure(1500, 2500, 0, 65535, 24, 3999, 3999, 1);
    sender_idle_pct = 0;
    receiver_stall_pct = 52;
    run_patrol(250);
  endtask

  // Both sides idle now and then, first with patrol off and degenerate sectors, then with
  // every range outside the accepted window but the top one.
  task automatic test_both_sides_idle();
    wait_drained();
    configure(65535, 0, 0, 65535, 1, 1, 1, 0);
    sender_idle_pct = 12;
    receiver_stall_pct = 12;
    run_patrol(120);
    wait_drained();
    configure(0, 65535, 65535, 65535, 9, 4000, 0, 1);
    run_patrol(130);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the result
  // register fills and the block stalls its input; then the sender waits for a full drain.
  task automatic test_backpressure();
    wait_drained();
    configure(2000, 3000, 0, 65535, 12, 1200, 800, 1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_cycles = 200;
    send_ticks(20);
    send_scan(12);
    send_ticks(20);
    wait_drained();
    send_ticks(5);
    send_scan(12);
  endtask

  // A long scan whose samples run on past its end, where they fall in no sector.
  task automatic test_long_scan();
    wait_drained();
    configure(2000, 3000, 0, 65535, 256, 400, 500, 1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_scan(300);
    send_ticks(2);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_SAMPLE;
    range_mm = '0;
    sample_valid = 1'b0;
    last_sample = 1'b0;
    chance_return = '0;
    chance_explore = '0;
    reset_navigation();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_steady_patrol();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_backpressure();
    test_long_scan();

    wait_drained();
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
